// File: src/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants, types and width helpers of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int ENTRY_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Operand positions of each adjugate entry, in output order: p*q - r*s.
    typedef logic [3:0] mi3_idx_t;
    localparam mi3_idx_t ADJ_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Fill level of the queue between the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } mi3_qstat_t;

    // Width of one queued request: singular, determinant sign, nine adjugate
    // signs, determinant magnitude and nine scaled numerator magnitudes.
    function automatic int mi3_payload_width(input int w, input int f);
        return 2 + 9 + (3 * w + 3) + 9 * (2 * w + 1 + 2 * f);
    endfunction

endpackage

// File: src/mi3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Accepts matrices, forms cofactors and determinant, and classifies each
// request into signs and magnitudes for the divider.
// ----------------------------------------------------------------------------
module mi3_front #(
    parameter int ENTRY_WIDTH   = mi3_pkg::ENTRY_WIDTH_DEF,
    parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ENTRY_WIDTH-1:0] m [9],
    input  mi3_pkg::mi3_qstat_t           qstat,
    output logic                          push,
    output logic [mi3_pkg::mi3_payload_width(ENTRY_WIDTH, FRACTION_BITS)-1:0] data
);
    import mi3_pkg::*;

    localparam int W   = ENTRY_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int AW  = 2 * W + 1;
    localparam int TW  = 3 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = AW + 2 * F;
    localparam int PLW = mi3_payload_width(W, F);

    logic [6:0]              v_reg;
    logic                    fen;

    logic signed [W-1:0]     s1_m_reg   [9];
    logic signed [2*W-1:0]   s2_pa_reg  [9];
    logic signed [2*W-1:0]   s2_pb_reg  [9];
    logic signed [W-1:0]     s2_r_reg   [3];
    logic signed [AW-1:0]    s3_adj_reg [9];
    logic signed [W-1:0]     s3_r_reg   [3];
    logic signed [2*W:0]     s4_lo_reg  [3];
    logic signed [2*W:0]     s4_hi_reg  [3];
    logic signed [AW-1:0]    s4_adj_reg [9];
    logic signed [TW-1:0]    s5_t_reg   [3];
    logic signed [AW-1:0]    s5_adj_reg [9];
    logic signed [DW-1:0]    s6_det_reg;
    logic signed [AW-1:0]    s6_adj_reg [9];
    logic [PLW-1:0]          data_reg;

    logic signed [W:0]       lo_op [3];
    logic signed [W:0]       hi_op [3];
    logic [PLW-1:0]          data_next;
    logic                    dneg;
    logic [DW-1:0]           dmag;
    logic [AW-1:0]           amag;

    assign fen      = !(v_reg[6] && qstat.full);
    assign in_stall = !fen;
    assign push     = v_reg[6] && !qstat.full;
    assign data     = data_reg;

    // The adjugate is split into an unsigned low half and a signed high half
    // so that each determinant product stays near W by W bits.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_op[j] = $signed({1'b0, s3_adj_reg[3*j][W-1:0]});
            hi_op[j] = $signed(s3_adj_reg[3*j][AW-1:W]);
        end
    end

    always_comb
    begin
        dneg = s6_det_reg[DW-1];
        dmag = dneg ? DW'(-s6_det_reg) : DW'(s6_det_reg);
        data_next = '0;
        for (int k = 0; k < 9; k++)
        begin
            amag = s6_adj_reg[k][AW-1] ? AW'(-s6_adj_reg[k]) : AW'(s6_adj_reg[k]);
            data_next[k*NW +: NW] = {amag, {(2*F){1'b0}}};
            data_next[9*NW + DW + k] = s6_adj_reg[k][AW-1];
        end
        data_next[9*NW +: DW] = dmag;
        data_next[PLW-2]      = dneg;
        data_next[PLW-1]      = (s6_det_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (fen)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            for (int k = 0; k < 9; k++)
            begin
                s1_m_reg[k]   <= m[k];
                s2_pa_reg[k]  <= s1_m_reg[ADJ_IDX[k][0]] * s1_m_reg[ADJ_IDX[k][1]];
                s2_pb_reg[k]  <= s1_m_reg[ADJ_IDX[k][2]] * s1_m_reg[ADJ_IDX[k][3]];
                s3_adj_reg[k] <= AW'(s2_pa_reg[k]) - AW'(s2_pb_reg[k]);
                s4_adj_reg[k] <= s3_adj_reg[k];
                s5_adj_reg[k] <= s4_adj_reg[k];
                s6_adj_reg[k] <= s5_adj_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                s2_r_reg[j]  <= s1_m_reg[j];
                s3_r_reg[j]  <= s2_r_reg[j];
                s4_lo_reg[j] <= s3_r_reg[j] * lo_op[j];
                s4_hi_reg[j] <= s3_r_reg[j] * hi_op[j];
                s5_t_reg[j]  <= $signed({s4_hi_reg[j], {W{1'b0}}}) + TW'(s4_lo_reg[j]);
            end
            s6_det_reg <= DW'(s5_t_reg[0]) + DW'(s5_t_reg[1]) + DW'(s5_t_reg[2]);
            data_reg   <= data_next;
        end
    end

endmodule

// File: src/mi3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module mi3_queue #(
    parameter int WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wdata,
    input  logic                pop,
    output logic [WIDTH-1:0]    rdata,
    output mi3_pkg::mi3_qstat_t qstat
);
    import mi3_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;

    assign qstat.full  = (cnt_reg == 2'd2);
    assign qstat.empty = (cnt_reg == 2'd0);
    assign rdata       = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty)) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");

endmodule

// File: src/mi3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// Pipelined restoring divider over nine lanes, then sign, saturation and the
// output register.
// ----------------------------------------------------------------------------
module mi3_back #(
    parameter int ENTRY_WIDTH   = mi3_pkg::ENTRY_WIDTH_DEF,
    parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mi3_pkg::mi3_qstat_t           qstat,
    input  logic [mi3_pkg::mi3_payload_width(ENTRY_WIDTH, FRACTION_BITS)-1:0] qdata,
    output logic                          pop,
    output logic                          valid,
    input  logic                          stall,
    output logic signed [ENTRY_WIDTH-1:0] inv [9],
    output logic                          singular,
    output logic                          saturated
);
    import mi3_pkg::*;

    localparam int W   = ENTRY_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int AW  = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = AW + 2 * F;
    localparam int QB  = W + 1;
    localparam int PLW = mi3_payload_width(W, F);
    localparam int CW  = ((NW > DW + QB) ? NW : DW + QB) + 1;
    localparam logic [QB-1:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

    typedef struct packed {
        logic [8:0][CW-1:0] rem;
        logic [8:0][QB-1:0] q;
        logic [8:0]         over;
        logic [8:0]         neg;
        logic [DW-1:0]      dmag;
        logic               singular;
    } stage_t;

    stage_t              st_reg  [QB+1];
    stage_t              st_next [QB+1];
    logic [QB:0]         v_reg;
    logic                valid_reg;
    logic signed [W-1:0] inv_reg [9];
    logic signed [W-1:0] inv_next [9];
    logic                singular_reg;
    logic                saturated_reg;
    logic                saturated_next;
    logic                ben;
    logic [CW-1:0]       sh;
    logic [CW:0]         diff;
    logic [QB-1:0]       lim;
    logic [QB-1:0]       qv;
    logic [QB-1:0]       sv;
    logic                clip;

    assign ben       = !(valid_reg && stall);
    assign pop       = ben && !qstat.empty;
    assign valid     = valid_reg;
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            inv[k] = inv_reg[k];
        end
    end

    // Stage zero unpacks the request and flags quotients of more than QB bits.
    always_comb
    begin
        st_next[0].dmag     = qdata[9*NW +: DW];
        st_next[0].singular = qdata[PLW-1];
        for (int k = 0; k < 9; k++)
        begin
            st_next[0].rem[k]  = CW'(qdata[k*NW +: NW]);
            st_next[0].q[k]    = '0;
            st_next[0].neg[k]  = qdata[9*NW + DW + k] ^ qdata[PLW-2];
            st_next[0].over[k] = CW'(qdata[k*NW +: NW]) >= (CW'(qdata[9*NW +: DW]) << QB);
        end
        for (int s = 0; s < QB; s++)
        begin
            st_next[s+1] = st_reg[s];
            sh = CW'(st_reg[s].dmag) << (QB - 1 - s);
            for (int k = 0; k < 9; k++)
            begin
                diff = {1'b0, st_reg[s].rem[k]} - {1'b0, sh};
                if (!diff[CW])
                begin
                    st_next[s+1].rem[k]           = diff[CW-1:0];
                    st_next[s+1].q[k][QB - 1 - s] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        saturated_next = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            lim  = st_reg[QB].neg[k] ? LIM_NEG : LIM_POS;
            clip = st_reg[QB].over[k] || (st_reg[QB].q[k] > lim);
            qv   = clip ? lim : st_reg[QB].q[k];
            sv   = st_reg[QB].neg[k] ? -qv : qv;
            if (st_reg[QB].singular)
            begin
                inv_next[k] = '0;
            end
            else
            begin
                inv_next[k]    = $signed(sv[W-1:0]);
                saturated_next = saturated_next | clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else if (ben)
        begin
            v_reg     <= {v_reg[QB-1:0], pop};
            valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                st_reg[s] <= st_next[s];
            end
            for (int k = 0; k < 9; k++)
            begin
                inv_reg[k] <= inv_next[k];
            end
            singular_reg  <= st_reg[QB].singular;
            saturated_reg <= saturated_next;
        end
    end

    a_singular_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && singular_reg |-> !saturated_reg)
        else $error("singular result flagged as saturated");
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && singular_reg |-> inv_reg[0] == '0 && inv_reg[4] == '0 && inv_reg[8] == '0)
        else $error("singular result carries nonzero entries");
    a_zero_det_over: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && st_reg[0].singular |-> &st_reg[0].over)
        else $error("zero determinant not seen as overflow");

endmodule

// File: src/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Fixed-point inverse of a 3x3 matrix by the adjugate method.
//
//   Channel   Handshake          Payload
//   input     m_valid/m_stall    m_00 .. m_22
//   output    inv_valid/inv_stall inv_00 .. inv_22, singular, saturated
//
// One matrix is taken per cycle while m_stall is low; the pipelined divider sets the rate.
// Results pass through seven front stages, the queue, ENTRY_WIDTH + 2 divider
// stages and the output register.
// Reset clears all valid bits and the queue; no clearing pass is needed.
// m_stall rises only when the two-entry queue is full with a request waiting;
// the back holds while a result waits under inv_stall.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int ENTRY_WIDTH   = mi3_pkg::ENTRY_WIDTH_DEF,
    parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_valid,
    output logic                          m_stall,
    input  logic signed [ENTRY_WIDTH-1:0] m_00,
    input  logic signed [ENTRY_WIDTH-1:0] m_01,
    input  logic signed [ENTRY_WIDTH-1:0] m_02,
    input  logic signed [ENTRY_WIDTH-1:0] m_10,
    input  logic signed [ENTRY_WIDTH-1:0] m_11,
    input  logic signed [ENTRY_WIDTH-1:0] m_12,
    input  logic signed [ENTRY_WIDTH-1:0] m_20,
    input  logic signed [ENTRY_WIDTH-1:0] m_21,
    input  logic signed [ENTRY_WIDTH-1:0] m_22,
    output logic                          inv_valid,
    input  logic                          inv_stall,
    output logic signed [ENTRY_WIDTH-1:0] inv_00,
    output logic signed [ENTRY_WIDTH-1:0] inv_01,
    output logic signed [ENTRY_WIDTH-1:0] inv_02,
    output logic signed [ENTRY_WIDTH-1:0] inv_10,
    output logic signed [ENTRY_WIDTH-1:0] inv_11,
    output logic signed [ENTRY_WIDTH-1:0] inv_12,
    output logic signed [ENTRY_WIDTH-1:0] inv_20,
    output logic signed [ENTRY_WIDTH-1:0] inv_21,
    output logic signed [ENTRY_WIDTH-1:0] inv_22,
    output logic                          singular,
    output logic                          saturated
);
    import mi3_pkg::*;

    localparam int PLW = mi3_payload_width(ENTRY_WIDTH, FRACTION_BITS);

    logic signed [ENTRY_WIDTH-1:0] m   [9];
    logic signed [ENTRY_WIDTH-1:0] inv [9];
    mi3_qstat_t                    qstat;
    logic                          push;
    logic                          pop;
    logic [PLW-1:0]                wdata;
    logic [PLW-1:0]                rdata;

    assign m[0] = m_00;
    assign m[1] = m_01;
    assign m[2] = m_02;
    assign m[3] = m_10;
    assign m[4] = m_11;
    assign m[5] = m_12;
    assign m[6] = m_20;
    assign m[7] = m_21;
    assign m[8] = m_22;

    assign inv_00 = inv[0];
    assign inv_01 = inv[1];
    assign inv_02 = inv[2];
    assign inv_10 = inv[3];
    assign inv_11 = inv[4];
    assign inv_12 = inv[5];
    assign inv_20 = inv[6];
    assign inv_21 = inv[7];
    assign inv_22 = inv[8];

    mi3_front #(
        .ENTRY_WIDTH   (ENTRY_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m_valid),
        .in_stall (m_stall),
        .m        (m),
        .qstat    (qstat),
        .push     (push),
        .data     (wdata)
    );

    mi3_queue #(
        .WIDTH (PLW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .qstat (qstat)
    );

    mi3_back #(
        .ENTRY_WIDTH   (ENTRY_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .qdata     (rdata),
        .pop       (pop),
        .valid     (inv_valid),
        .stall     (inv_stall),
        .inv       (inv),
        .singular  (singular),
        .saturated (saturated)
    );

endmodule
